[design/whole_word_replace_stream_core_macros.svh]
// Assertion macros for the verification files of the word replace core.
// No dependencies; included by the checker module.
`ifndef WHOLE_WORD_REPLACE_STREAM_CORE_MACROS_SVH
`define WHOLE_WORD_REPLACE_STREAM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WWR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("word replace core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("word replace core: next-cycle check failed");

`endif

[design/wwr_pkg.sv]
// Shared constants, types and helper functions of the word replace core.
// No dependencies; used by every other design file except the assertion macro header.
package wwr_pkg;

  localparam int MaxWord = 8;
  localparam int ByteW   = 8;
  localparam int CntW    = $clog2(MaxWord + 1);
  localparam int IdxW    = (MaxWord > 1) ? $clog2(MaxWord) : 1;
  localparam int TotalW  = 16;
  localparam int CfgW    = MaxWord * ByteW;
  localparam int CfgIdxW = 2;

  typedef logic [MaxWord-1:0][ByteW-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_TEXT        = 2'd0,
    CFG_TARGET_LENGTH      = 2'd1,
    CFG_REPLACEMENT_TEXT   = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    word_t             win;
    logic [CntW-1:0]   cnt;
    logic              bib;
    logic [TotalW-1:0] ctr;
  } state_t;

  // Results of one item: a first group (pops or a replacement before the
  // new byte is queued) and a second group (the end-of-text flush).
  typedef struct packed {
    word_t             a_chars;
    logic [CntW-1:0]   a_n;
    logic [TotalW-1:0] tot_a;
    word_t             b_chars;
    logic [CntW-1:0]   b_n;
    logic [TotalW-1:0] tot_b;
    logic              last;
  } burst_t;

  // C-locale white space or punctuation.
  function automatic logic is_boundary(input logic [ByteW-1:0] c);
    logic res;
    case (c) inside
      [8'h09:8'h0D], 8'h20, [8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60],
      [8'h7B:8'h7E]: res = 1'b1;
      default:       res = 1'b0;
    endcase
    return res;
  endfunction

  // Zero counts as one, anything above the window size as the window size.
  function automatic logic [CntW-1:0] clamp_len(input logic [CntW-1:0] len);
    logic [CntW-1:0] res;
    if (len == '0) begin
      res = CntW'(1);
    end else if (len > CntW'(MaxWord)) begin
      res = CntW'(MaxWord);
    end else begin
      res = len;
    end
    return res;
  endfunction

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
    return (v == '1) ? v : v + TotalW'(1);
  endfunction

endpackage

[design/wwr_in_if.sv]
// Input channel of the word replace core: one text byte and its last flag.
// Depends on wwr_pkg for the byte width.
interface wwr_in_if;
  logic                    valid;
  logic                    ready;
  logic [wwr_pkg::ByteW-1:0] in_char;
  logic                    in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

[design/wwr_out_if.sv]
// Output channel of the word replace core: one corrected byte per item.
// Depends on wwr_pkg for the field widths.
interface wwr_out_if;
  logic                       valid;
  logic                       ready;
  logic [wwr_pkg::ByteW-1:0]  out_char;
  logic                       out_last;
  logic [wwr_pkg::TotalW-1:0] replace_total;

  modport source (output valid, output out_char, output out_last, output replace_total,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input replace_total,
                  output ready);
endinterface

[design/wwr_step.sv]
// Next-state and result logic for one text byte of the word replace core.
// Purely combinational; depends on wwr_pkg.
module wwr_step (
  input  wwr_pkg::state_t                 state_i,
  input  logic [wwr_pkg::ByteW-1:0]      char_i,
  input  logic                           last_i,
  input  wwr_pkg::word_t                 target_i,
  input  logic [wwr_pkg::CntW-1:0]       target_len_i,
  input  wwr_pkg::word_t                 repl_i,
  input  logic [wwr_pkg::CntW-1:0]       repl_len_i,
  output wwr_pkg::state_t                state_o,
  output wwr_pkg::burst_t                burst_o
);

  function automatic logic window_eq(input wwr_pkg::word_t win, input wwr_pkg::word_t tgt,
                                     input logic [wwr_pkg::CntW-1:0] len);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < wwr_pkg::MaxWord; i++) begin
      if ((wwr_pkg::CntW'(i) < len) && (win[i] != tgt[i])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

  logic [wwr_pkg::CntW-1:0]   len_c;
  logic [wwr_pkg::CntW-1:0]   rlen_c;
  logic [wwr_pkg::IdxW-1:0]   tail_idx;
  logic                       match0;
  logic                       match2;
  logic                       drained;
  wwr_pkg::word_t             win1;
  wwr_pkg::word_t             win2;
  logic [wwr_pkg::CntW-1:0]   cnt1;
  logic [wwr_pkg::CntW-1:0]   cnt2;
  logic                       bib1;
  logic [wwr_pkg::TotalW-1:0] ctr1;
  logic [wwr_pkg::TotalW-1:0] ctr2;

  always_comb begin
    len_c    = wwr_pkg::clamp_len(target_len_i);
    rlen_c   = wwr_pkg::clamp_len(repl_len_i);
    tail_idx = wwr_pkg::IdxW'(len_c - wwr_pkg::CntW'(1));
    match0   = (state_i.cnt == len_c) && state_i.bib &&
               window_eq(state_i.win, target_i, len_c);

    win1    = state_i.win;
    cnt1    = state_i.cnt;
    bib1    = state_i.bib;
    ctr1    = state_i.ctr;
    drained = 1'b0;
    burst_o = '0;

    // First group: make room for the new byte.
    if (state_i.cnt > len_c) begin
      // The target was shortened: two old bytes leave untested.
      burst_o.a_chars[0] = state_i.win[0];
      burst_o.a_chars[1] = state_i.win[1];
      burst_o.a_n        = wwr_pkg::CntW'(2);
      win1    = {{(2 * wwr_pkg::ByteW){1'b0}}, state_i.win[wwr_pkg::MaxWord-1:2]};
      cnt1    = state_i.cnt - wwr_pkg::CntW'(2);
      bib1    = wwr_pkg::is_boundary(state_i.win[1]);
      drained = 1'b1;
    end else if (state_i.cnt == len_c) begin
      if (match0 && wwr_pkg::is_boundary(char_i)) begin
        burst_o.a_chars = repl_i;
        burst_o.a_n     = rlen_c;
        cnt1 = '0;
        bib1 = wwr_pkg::is_boundary(state_i.win[tail_idx]);
        ctr1 = wwr_pkg::sat_inc(state_i.ctr);
      end else begin
        burst_o.a_chars[0] = state_i.win[0];
        burst_o.a_n        = wwr_pkg::CntW'(1);
        win1 = {{wwr_pkg::ByteW{1'b0}}, state_i.win[wwr_pkg::MaxWord-1:1]};
        cnt1 = state_i.cnt - wwr_pkg::CntW'(1);
        bib1 = wwr_pkg::is_boundary(state_i.win[0]);
      end
    end

    // Queue the new byte; the window never holds more than MaxWord-1 here.
    win2 = win1;
    win2[wwr_pkg::IdxW'(cnt1)] = char_i;
    cnt2 = cnt1 + wwr_pkg::CntW'(1);

    match2 = !drained && (cnt2 == len_c) && bib1 && window_eq(win2, target_i, len_c);
    ctr2   = ctr1;

    if (last_i) begin
      // End of text counts as a boundary, then everything left goes out.
      if (match2) begin
        burst_o.b_chars = repl_i;
        burst_o.b_n     = rlen_c;
        ctr2            = wwr_pkg::sat_inc(ctr1);
      end else begin
        burst_o.b_chars = win2;
        burst_o.b_n     = cnt2;
      end
      state_o.win = win2;
      state_o.cnt = '0;
      state_o.bib = 1'b1;
      state_o.ctr = '0;
    end else begin
      state_o.win = win2;
      state_o.cnt = cnt2;
      state_o.bib = bib1;
      state_o.ctr = ctr1;
    end

    burst_o.tot_a = ctr1;
    burst_o.tot_b = ctr2;
    burst_o.last  = last_i;
  end

endmodule

[design/wwr_burst.sv]
// Result register of the word replace core: holds the results of one item and
// hands them out one per handshake. Depends on wwr_pkg.
module wwr_burst (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  wwr_pkg::burst_t             burst_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [wwr_pkg::ByteW-1:0]   out_char_o,
  output logic                        out_last_o,
  output logic [wwr_pkg::TotalW-1:0]  out_total_o,
  output logic                        free_o
);

  wwr_pkg::word_t             a_q, a_d, b_q, b_d;
  logic [wwr_pkg::CntW-1:0]   na_q, na_d, nb_q, nb_d;
  logic [wwr_pkg::TotalW-1:0] tota_q, tota_d, totb_q, totb_d;
  logic                       last_q, last_d;
  logic [wwr_pkg::CntW:0]     remain;
  logic                       pop;
  logic                       from_a;

  assign from_a      = (na_q != '0);
  assign remain      = {1'b0, na_q} + {1'b0, nb_q};
  assign out_valid_o = (remain != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_char_o  = from_a ? a_q[0] : b_q[0];
  assign out_total_o = from_a ? tota_q : totb_q;
  assign out_last_o  = last_q && (remain == (wwr_pkg::CntW + 1)'(1));
  assign free_o      = (remain == '0) ||
                       ((remain == (wwr_pkg::CntW + 1)'(1)) && out_ready_i);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    na_d   = na_q;
    nb_d   = nb_q;
    tota_d = tota_q;
    totb_d = totb_q;
    last_d = last_q;
    if (load_i) begin
      a_d    = burst_i.a_chars;
      b_d    = burst_i.b_chars;
      na_d   = burst_i.a_n;
      nb_d   = burst_i.b_n;
      tota_d = burst_i.tot_a;
      totb_d = burst_i.tot_b;
      last_d = burst_i.last;
    end else if (pop) begin
      if (from_a) begin
        a_d  = {{wwr_pkg::ByteW{1'b0}}, a_q[wwr_pkg::MaxWord-1:1]};
        na_d = na_q - wwr_pkg::CntW'(1);
      end else begin
        b_d  = {{wwr_pkg::ByteW{1'b0}}, b_q[wwr_pkg::MaxWord-1:1]};
        nb_d = nb_q - wwr_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      na_q   <= '0;
      nb_q   <= '0;
      last_q <= 1'b0;
    end else begin
      na_q   <= na_d;
      nb_q   <= nb_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    tota_q <= tota_d;
    totb_q <= totb_d;
  end

endmodule

[design/whole_word_replace_stream_core.sv]
// Whole-word find and replace over a byte stream. Text bytes enter on in_i, with
// in_last on the final byte, and corrected bytes leave on out_o. A pending window
// as long as the target word is compared in parallel against the target; when it
// matches, the byte before it was start of text, white space or punctuation, and
// the byte after it is white space, punctuation or end of text, the replacement
// word goes out instead and replace_total counts it (saturating at 65535). The
// final output byte carries out_last and the final count, after which the block
// is ready for a new text. A byte causing at most one output byte does not hold
// the input while the output port takes bytes; bytes causing none keep entering
// while earlier output drains. A byte causing more than one output byte (a
// replacement, or the end-of-text flush, up to 16) holds the next byte back until
// the single-byte output port has drained the result register. First output comes
// after the byte passes the input register and then the result register. The four
// configuration registers may be written only while the block is idle.
module whole_word_replace_stream_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wwr_in_if.sink                          in_i,
  wwr_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [wwr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wwr_pkg::CfgW-1:0]        cfg_data_i
);

  // Configuration registers. Lengths are kept as written and clamped on use.
  wwr_pkg::word_t             target_q;
  logic [wwr_pkg::CntW-1:0]   target_len_q;
  wwr_pkg::word_t             repl_q;
  logic [wwr_pkg::CntW-1:0]   repl_len_q;

  // Input register: it lets a new byte in while the result register still
  // waits on the output side.
  logic                       inq_valid_q, inq_valid_d;
  logic [wwr_pkg::ByteW-1:0]  inq_char_q;
  logic                       inq_last_q;

  // Matcher state. The window bytes hold no reset; only entries below the
  // pending count are ever compared or sent.
  wwr_pkg::word_t             win_q;
  logic [wwr_pkg::CntW-1:0]   cnt_q;
  logic                       bib_q;
  logic [wwr_pkg::TotalW-1:0] ctr_q;

  wwr_pkg::state_t            state_cur;
  wwr_pkg::state_t            state_nxt;
  wwr_pkg::burst_t            burst;
  logic                       burst_free;
  logic                       burst_empty;
  logic                       advance;
  logic                       in_fire;

  assign state_cur.win = win_q;
  assign state_cur.cnt = cnt_q;
  assign state_cur.bib = bib_q;
  assign state_cur.ctr = ctr_q;

  wwr_step u_step (
    .state_i      (state_cur),
    .char_i       (inq_char_q),
    .last_i       (inq_last_q),
    .target_i     (target_q),
    .target_len_i (target_len_q),
    .repl_i       (repl_q),
    .repl_len_i   (repl_len_q),
    .state_o      (state_nxt),
    .burst_o      (burst)
  );

  // A held byte moves on when the result register can take its results, or at
  // once when it causes none, since then nothing has to wait behind the output.
  assign burst_empty = (burst.a_n == '0) && (burst.b_n == '0);
  assign advance     = inq_valid_q && (burst_free || burst_empty);
  assign in_i.ready  = !inq_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  wwr_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (inq_valid_q && burst_free),
    .burst_i     (burst),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_char_o  (out_o.out_char),
    .out_last_o  (out_o.out_last),
    .out_total_o (out_o.replace_total),
    .free_o      (burst_free)
  );

  always_comb begin
    inq_valid_d = inq_valid_q;
    if (in_fire) begin
      inq_valid_d = 1'b1;
    end else if (advance) begin
      inq_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      cnt_q       <= '0;
      bib_q       <= 1'b1;
      ctr_q       <= '0;
    end else begin
      inq_valid_q <= inq_valid_d;
      if (advance) begin
        cnt_q <= state_nxt.cnt;
        bib_q <= state_nxt.bib;
        ctr_q <= state_nxt.ctr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_char_q <= in_i.in_char;
      inq_last_q <= in_i.in_last;
    end
    if (advance) begin
      win_q <= state_nxt.win;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      target_len_q <= wwr_pkg::CntW'(1);
      repl_q       <= '0;
      repl_len_q   <= wwr_pkg::CntW'(1);
    end else if (cfg_we_i) begin
      unique case (wwr_pkg::cfg_idx_e'(cfg_idx_i))
        wwr_pkg::CFG_TARGET_TEXT:        target_q     <= cfg_data_i;
        wwr_pkg::CFG_TARGET_LENGTH:      target_len_q <= cfg_data_i[wwr_pkg::CntW-1:0];
        wwr_pkg::CFG_REPLACEMENT_TEXT:   repl_q       <= cfg_data_i;
        wwr_pkg::CFG_REPLACEMENT_LENGTH: repl_len_q   <= cfg_data_i[wwr_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/wwr_checker.sv]
// Port-level checks of the word replace core, bound to its top level.
// Depends on wwr_pkg and the shared assertion macro header.
`include "whole_word_replace_stream_core_macros.svh"

module wwr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [wwr_pkg::ByteW-1:0]  out_char_i,
  input logic                       out_last_i,
  input logic [wwr_pkg::TotalW-1:0] out_total_i
);

  logic                       out_fire;
  logic                       seen_q;
  logic                       prev_last_q;
  logic [wwr_pkg::TotalW-1:0] prev_total_q;

  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      prev_last_q  <= 1'b0;
      prev_total_q <= '0;
    end else if (out_fire) begin
      seen_q       <= 1'b1;
      prev_last_q  <= out_last_i;
      prev_total_q <= out_total_i;
    end
  end

  // A stalled output item keeps its payload.
  `WWR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_char_i) && $stable(out_last_i) && $stable(out_total_i))

  // The input only stalls while results are waiting to be taken.
  `WWR_ASSERT_NOW(a_stall_has_output, clk_i, rst_ni, !in_ready_i, out_valid_i)

  // Within one text the count never goes down.
  `WWR_ASSERT_NOW(a_total_monotonic, clk_i, rst_ni, out_fire && seen_q && !prev_last_q,
                  out_total_i >= prev_total_q)

  // A new text starts counting from zero again.
  `WWR_ASSERT_NOW(a_total_restart, clk_i, rst_ni, out_fire && seen_q && prev_last_q,
                  out_total_i <= wwr_pkg::TotalW'(1))

endmodule

bind whole_word_replace_stream_core wwr_checker u_wwr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_last_i  (out_o.out_last),
  .out_total_i (out_o.replace_total)
);
